// ===== src/gn_pkg.sv =====
// Shared widths, constants and codes of the 2-D gradient noise block.
// No dependencies; every other file except gn_ram imports this package.
`timescale 1ns / 1ps

package gn_pkg;

    localparam int COORD_W     = 24;
    localparam int CELL_W      = 12;
    localparam int FRAC_W      = 16;
    localparam int IDX_W       = 10;
    localparam int TABLE_DEPTH = 1 << IDX_W;
    localparam int GRAD_W      = 16;
    localparam int NOISE_W     = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Depth of the pipelined floor divider: magnitude capture, one stage per
    // quotient bit, the sign fix-up and one stage per fraction bit.
    localparam int DIV_STAGES  = COORD_W + FRAC_W + 2;

    localparam logic [CELL_W-1:0] CELL_SIZE_RESET = 12'd70;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } opcode_t;

    // Register index as seen in bit 2 of the byte address.
    typedef enum logic [0:0] {
        REG_CELL_SIZE = 1'b0,
        REG_NONE      = 1'b1
    } reg_idx_t;

endpackage

// ===== src/gn_ifs.sv =====
// Valid/ready channel interfaces for sample items and noise results.
// Depends on gn_pkg for field widths.
`timescale 1ns / 1ps

interface gn_in_if import gn_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;
    logic [IDX_W-1:0]          entry_index;
    logic signed [GRAD_W-1:0]  grad_x;
    logic signed [GRAD_W-1:0]  grad_y;

    modport source (output valid, opcode, sample_x, sample_y, entry_index, grad_x, grad_y,
                    input ready);
    modport sink   (input valid, opcode, sample_x, sample_y, entry_index, grad_x, grad_y,
                    output ready);
endinterface

interface gn_out_if import gn_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [NOISE_W-1:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

// ===== src/gn_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gn_div.sv =====
// Pipelined restoring floor divider: one coordinate by the cell size, giving the
// low bits of the lattice cell and a Q0.16 offset. Depends on gn_pkg.
`timescale 1ns / 1ps

module gn_div import gn_pkg::*; (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] coord,
    input  logic [CELL_W-1:0]         divisor,
    output logic [IDX_W-1:0]          cell_lo,
    output logic [FRAC_W-1:0]         frac
);

    logic [COORD_W-1:0] num_reg  [0:COORD_W];
    logic [CELL_W-1:0]  rem_reg  [0:COORD_W];
    logic               neg_reg  [0:COORD_W];
    logic [IDX_W-1:0]   cell_reg [0:FRAC_W];
    logic [CELL_W-1:0]  frem_reg [0:FRAC_W];
    logic [FRAC_W-1:0]  fq_reg   [0:FRAC_W];

    logic [COORD_W-1:0] mag;
    logic [IDX_W-1:0]   q_lo;
    logic               rem_nz;

    assign mag    = coord[COORD_W-1] ? COORD_W'(-coord) : COORD_W'(coord);
    assign q_lo   = num_reg[COORD_W][IDX_W-1:0];
    assign rem_nz = (rem_reg[COORD_W] != '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= mag;
            rem_reg[0] <= '0;
            neg_reg[0] <= coord[COORD_W-1];
            // Floor adjustment: a negative dividend with a remainder steps one cell down.
            if (neg_reg[COORD_W])
            begin
                cell_reg[0] <= rem_nz ? ~q_lo : IDX_W'(-q_lo);
                frem_reg[0] <= rem_nz ? CELL_W'(divisor - rem_reg[COORD_W]) : '0;
            end
            else
            begin
                cell_reg[0] <= q_lo;
                frem_reg[0] <= rem_reg[COORD_W];
            end
            fq_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < COORD_W; k++)
    begin : g_quot
        logic [CELL_W:0] trial;
        logic            fit;
        assign trial = {rem_reg[k], num_reg[k][COORD_W-1]};
        assign fit   = (trial >= {1'b0, divisor});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= fit ? CELL_W'(trial - {1'b0, divisor}) : trial[CELL_W-1:0];
                num_reg[k+1] <= {num_reg[k][COORD_W-2:0], fit};
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    for (genvar j = 0; j < FRAC_W; j++)
    begin : g_frac
        logic [CELL_W:0] trial;
        logic            fit;
        assign trial = {frem_reg[j], 1'b0};
        assign fit   = (trial >= {1'b0, divisor});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                frem_reg[j+1] <= fit ? CELL_W'(trial - {1'b0, divisor}) : trial[CELL_W-1:0];
                fq_reg[j+1]   <= {fq_reg[j][FRAC_W-2:0], fit};
                cell_reg[j+1] <= cell_reg[j];
            end
        end
    end

    assign cell_lo = cell_reg[FRAC_W];
    assign frac    = fq_reg[FRAC_W];

endmodule

// ===== src/gradient_noise_2d.sv =====
// Pipeline: an evaluate transfer passes through 42 divider stages, 6
// gradient/fade/blend stages and one output register before its result appears.
// Throughput: one item per cycle while the output is not blocked; set by the fully pipelined bit-per-stage divider.
// The gradient table memories are written as loads reach the lookup stage.
// Reset clears all valid flags and sets cell_size to 70; table contents are
// undefined until loaded, and no clearing pass runs.
`timescale 1ns / 1ps

module gradient_noise_2d import gn_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    gn_in_if.sink                 sample_in,
    gn_out_if.source              noise_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration: cell size register. Zero is treated as one.
    // ------------------------------------------------------------------
    logic [CELL_W-1:0] cell_size_reg;
    logic [CELL_W-1:0] divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= CELL_SIZE_RESET;
        end
        else if (psel && penable && pwrite && (reg_idx_t'(paddr[2]) == REG_CELL_SIZE))
        begin
            cell_size_reg <= pwdata[CELL_W-1:0];
        end
    end

    assign pready  = 1'b1;
    assign prdata  = (reg_idx_t'(paddr[2]) == REG_CELL_SIZE)
                   ? APB_DATA_W'(cell_size_reg) : '0;
    assign divisor = (cell_size_reg == '0) ? CELL_W'(1) : cell_size_reg;

    // ------------------------------------------------------------------
    // Pipeline advance. The whole pipeline moves together and only stops
    // when a finished result sits in the last stage and the output
    // register is still holding an untaken result.
    // ------------------------------------------------------------------
    logic [6:1] ev_reg;
    logic       out_valid_reg;
    logic       en;
    logic       accept;

    assign en               = !ev_reg[6] || !out_valid_reg || noise_out.ready;
    assign accept           = sample_in.valid && en;
    assign sample_in.ready  = en;

    // ------------------------------------------------------------------
    // Side line: the item's opcode and load data travel alongside the
    // divider so that loads and evaluates reach the table in order.
    // ------------------------------------------------------------------
    function automatic logic signed [GRAD_W-1:0] clamp_grad(input logic signed [GRAD_W-1:0] g);
        logic signed [GRAD_W-1:0] lim;
        lim = GRAD_W'(16384);
        if (g > lim)
        begin
            return lim;
        end
        else if (g < -lim)
        begin
            return -lim;
        end
        return g;
    endfunction

    logic                     sd_valid_reg [0:DIV_STAGES-1];
    opcode_t                  sd_op_reg    [0:DIV_STAGES-1];
    logic [IDX_W-1:0]         sd_entry_reg [0:DIV_STAGES-1];
    logic signed [GRAD_W-1:0] sd_gx_reg    [0:DIV_STAGES-1];
    logic signed [GRAD_W-1:0] sd_gy_reg    [0:DIV_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                sd_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            sd_valid_reg[0] <= accept;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                sd_valid_reg[i] <= sd_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_op_reg[0]    <= opcode_t'(sample_in.opcode);
            sd_entry_reg[0] <= sample_in.entry_index;
            sd_gx_reg[0]    <= clamp_grad(sample_in.grad_x);
            sd_gy_reg[0]    <= clamp_grad(sample_in.grad_y);
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                sd_op_reg[i]    <= sd_op_reg[i-1];
                sd_entry_reg[i] <= sd_entry_reg[i-1];
                sd_gx_reg[i]    <= sd_gx_reg[i-1];
                sd_gy_reg[i]    <= sd_gy_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Floor division of each coordinate by the cell size.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  cx_lo;
    logic [IDX_W-1:0]  cy_lo;
    logic [FRAC_W-1:0] ux;
    logic [FRAC_W-1:0] uy;

    gn_div u_div_x (
        .clk     (clk),
        .en      (en),
        .coord   (sample_in.sample_x),
        .divisor (divisor),
        .cell_lo (cx_lo),
        .frac    (ux)
    );

    gn_div u_div_y (
        .clk     (clk),
        .en      (en),
        .coord   (sample_in.sample_y),
        .divisor (divisor),
        .cell_lo (cy_lo),
        .frac    (uy)
    );

    // ------------------------------------------------------------------
    // Stage E0: corner hashing and table access. Only the low ten bits of
    // the 32-bit hash survive the mask, so the multipliers are reduced
    // modulo 1024 as well. A load writes all four table copies here, in
    // the same stage where evaluates read, so program order is kept and
    // a read in the cycle after a write already sees the new entry.
    // ------------------------------------------------------------------
    localparam logic [IDX_W-1:0] HASH_MUL_X = 10'd351;
    localparam logic [IDX_W-1:0] HASH_MUL_Y = 10'd225;
    localparam logic [IDX_W-1:0] HASH_ADD   = 10'd576;

    function automatic logic [IDX_W-1:0] corner_hash(input logic [IDX_W-1:0] hcx,
                                                     input logic [IDX_W-1:0] hcy);
        logic [2*IDX_W-1:0] hx;
        logic [2*IDX_W-1:0] hy;
        hx = {{IDX_W{1'b0}}, hcx} * {{IDX_W{1'b0}}, HASH_MUL_X};
        hy = {{IDX_W{1'b0}}, hcy} * {{IDX_W{1'b0}}, HASH_MUL_Y};
        return hx[IDX_W-1:0] ^ IDX_W'(hy[IDX_W-1:0] + HASH_ADD);
    endfunction

    localparam int LAST = DIV_STAGES - 1;

    logic [IDX_W-1:0]        raddr [0:3];
    logic [2*GRAD_W-1:0]     rdata [0:3];
    logic                    tab_we;
    logic [IDX_W-1:0]        cx1_lo;
    logic [IDX_W-1:0]        cy1_lo;

    assign cx1_lo   = IDX_W'(cx_lo + 1'b1);
    assign cy1_lo   = IDX_W'(cy_lo + 1'b1);
    assign raddr[0] = corner_hash(cx_lo,  cy_lo);
    assign raddr[1] = corner_hash(cx1_lo, cy_lo);
    assign raddr[2] = corner_hash(cx_lo,  cy1_lo);
    assign raddr[3] = corner_hash(cx1_lo, cy1_lo);
    assign tab_we   = en && sd_valid_reg[LAST] && (sd_op_reg[LAST] == OP_LOAD)
                   && ({1'b0, sd_entry_reg[LAST]} < (IDX_W+1)'(TABLE_DEPTH));

    for (genvar c = 0; c < 4; c++)
    begin : g_tab
        gn_ram #(
            .WIDTH (2*GRAD_W),
            .DEPTH (TABLE_DEPTH)
        ) u_tab (
            .clk   (clk),
            .we    (tab_we),
            .waddr (sd_entry_reg[LAST]),
            .wdata ({sd_gx_reg[LAST], sd_gy_reg[LAST]}),
            .re    (en),
            .raddr (raddr[c]),
            .rdata (rdata[c])
        );
    end

    // Fade, first products: u*u and u*(6u - 15).
    logic signed [20:0] k6x, k6y;
    logic [31:0]        uux, uuy;
    logic signed [37:0] mix, miy;

    assign k6x = $signed(21'(ux) * 21'd6) - 21'sd983040;
    assign k6y = $signed(21'(uy) * 21'd6) - 21'sd983040;
    assign uux = 32'(ux) * 32'(ux);
    assign uuy = 32'(uy) * 32'(uy);
    assign mix = $signed({1'b0, ux}) * k6x;
    assign miy = $signed({1'b0, uy}) * k6y;

    // ------------------------------------------------------------------
    // Stage E1: dot-product terms, second fade products.
    // ------------------------------------------------------------------
    logic [FRAC_W-1:0]  ux1_reg, uy1_reg;
    logic [15:0]        t2x_reg, t2y_reg;
    logic signed [37:0] mix_reg, miy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux1_reg <= ux;
            uy1_reg <= uy;
            t2x_reg <= uux[31:16];
            t2y_reg <= uuy[31:16];
            mix_reg <= mix;
            miy_reg <= miy;
        end
    end

    logic signed [16:0]       dx0, dx1, dy0, dy1;
    logic signed [GRAD_W-1:0] gx [0:3];
    logic signed [GRAD_W-1:0] gy [0:3];
    logic signed [32:0]       px [0:3];
    logic signed [32:0]       py [0:3];
    logic [31:0]              t3x, t3y;
    logic signed [37:0]       shx, shy;

    // Offsets: u for the near corner, u minus one for the far corner.
    assign dx0 = $signed({1'b0, ux1_reg});
    assign dx1 = $signed({1'b1, ux1_reg});
    assign dy0 = $signed({1'b0, uy1_reg});
    assign dy1 = $signed({1'b1, uy1_reg});

    for (genvar c = 0; c < 4; c++)
    begin : g_dot
        assign gx[c] = $signed(rdata[c][2*GRAD_W-1:GRAD_W]);
        assign gy[c] = $signed(rdata[c][GRAD_W-1:0]);
        assign px[c] = ((c % 2) == 0 ? dx0 : dx1) * gx[c];
        assign py[c] = ((c / 2) == 0 ? dy0 : dy1) * gy[c];
    end

    assign t3x = 32'(t2x_reg) * 32'(ux1_reg);
    assign t3y = 32'(t2y_reg) * 32'(uy1_reg);
    assign shx = mix_reg >>> 16;
    assign shy = miy_reg >>> 16;

    // ------------------------------------------------------------------
    // Stage E2: dot sums and the last fade product.
    // ------------------------------------------------------------------
    logic signed [32:0] px_reg [0:3];
    logic signed [32:0] py_reg [0:3];
    logic [15:0]        t3x_reg, t3y_reg;
    logic [19:0]        inx_reg, iny_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                px_reg[c] <= px[c];
                py_reg[c] <= py[c];
            end
            t3x_reg <= t3x[31:16];
            t3y_reg <= t3y[31:16];
            inx_reg <= 20'(shx + 38'sd655360);
            iny_reg <= 20'(shy + 38'sd655360);
        end
    end

    logic signed [33:0] dsum [0:3];
    logic [35:0]        fpx, fpy;
    logic [16:0]        fx, fy;

    for (genvar c = 0; c < 4; c++)
    begin : g_sum
        assign dsum[c] = 34'(px_reg[c]) + 34'(py_reg[c]);
    end

    assign fpx = 36'(t3x_reg) * 36'(inx_reg);
    assign fpy = 36'(t3y_reg) * 36'(iny_reg);
    assign fx  = (fpx[35:16] > 20'd65536) ? 17'd65536 : fpx[32:16];
    assign fy  = (fpy[35:16] > 20'd65536) ? 17'd65536 : fpy[32:16];

    // ------------------------------------------------------------------
    // Stage E3: horizontal blend products.
    // ------------------------------------------------------------------
    logic signed [33:0] d_reg [0:3];
    logic [16:0]        fx3_reg, fy3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                d_reg[c] <= dsum[c];
            end
            fx3_reg <= fx;
            fy3_reg <= fy;
        end
    end

    logic signed [34:0] dtop, dbot;
    logic signed [17:0] sfx;
    logic signed [52:0] ptop, pbot;

    assign dtop = 35'(d_reg[1]) - 35'(d_reg[0]);
    assign dbot = 35'(d_reg[3]) - 35'(d_reg[2]);
    assign sfx  = $signed({1'b0, fx3_reg});
    assign ptop = dtop * sfx;
    assign pbot = dbot * sfx;

    // ------------------------------------------------------------------
    // Stage E4: horizontal blend results.
    // ------------------------------------------------------------------
    logic signed [52:0] ptop_reg, pbot_reg;
    logic signed [33:0] d00_reg, d01_reg;
    logic [16:0]        fy4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ptop_reg <= ptop;
            pbot_reg <= pbot;
            d00_reg  <= d_reg[0];
            d01_reg  <= d_reg[2];
            fy4_reg  <= fy3_reg;
        end
    end

    logic signed [52:0] sh_top, sh_bot;
    logic signed [34:0] top, bot;

    assign sh_top = ptop_reg >>> 16;
    assign sh_bot = pbot_reg >>> 16;
    assign top    = 35'(d00_reg) + 35'(sh_top);
    assign bot    = 35'(d01_reg) + 35'(sh_bot);

    // ------------------------------------------------------------------
    // Stage E5: vertical blend product.
    // ------------------------------------------------------------------
    logic signed [34:0] top_reg, bot_reg;
    logic [16:0]        fy5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_reg <= top;
            bot_reg <= bot;
            fy5_reg <= fy4_reg;
        end
    end

    logic signed [35:0] dvert;
    logic signed [53:0] pvert;

    assign dvert = 36'(bot_reg) - 36'(top_reg);
    assign pvert = dvert * $signed({1'b0, fy5_reg});

    // ------------------------------------------------------------------
    // Stage E6: final blend, rescale to (n+1)/2 in Q0.16 and saturate.
    // ------------------------------------------------------------------
    logic signed [53:0] pvert_reg;
    logic signed [34:0] top6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pvert_reg <= pvert;
            top6_reg  <= top_reg;
        end
    end

    logic signed [53:0] sh_vert;
    logic signed [36:0] n_biased;
    logic signed [36:0] scaled;
    logic [NOISE_W-1:0] noise;

    assign sh_vert  = pvert_reg >>> 16;
    assign n_biased = 37'(top6_reg) + 37'(sh_vert) + 37'sd1073741824;
    assign scaled   = n_biased >>> 15;

    always_comb
    begin
        priority if (scaled < 0)
        begin
            noise = '0;
        end
        else if (scaled > 37'sd65535)
        begin
            noise = '1;
        end
        else
        begin
            noise = scaled[NOISE_W-1:0];
        end
    end

    // Evaluate valid flags for stages E1..E6; loads end at E0.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= '0;
        end
        else if (en)
        begin
            ev_reg <= {ev_reg[5:1], sd_valid_reg[LAST] && (sd_op_reg[LAST] == OP_EVAL)};
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic [NOISE_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en && ev_reg[6])
        begin
            out_valid_reg <= 1'b1;
        end
        else if (noise_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && ev_reg[6])
        begin
            out_data_reg <= noise;
        end
    end

    assign noise_out.valid       = out_valid_reg;
    assign noise_out.noise_value = out_data_reg;

endmodule

// ===== src/gn_checker.sv =====
// Port-level checks for gradient_noise_2d, attached to it by a bind statement.
// Depends on gn_pkg.
`timescale 1ns / 1ps

module gn_checker import gn_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // A pending result is held until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // Input is only refused while the output is blocked.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without output back-pressure");

    // A written cell size reads back on the following cycle.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[2]
        |=> paddr[2] || (prdata[CELL_W-1:0] == $past(pwdata[CELL_W-1:0])))
        else $error("cell size readback mismatch");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind gradient_noise_2d gn_checker u_gn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sample_in.ready),
    .out_valid (noise_out.valid),
    .out_ready (noise_out.ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);

// ===== tb/sv/gn_noise_checker.sv =====
// Watching checker for the 2-D gradient noise block: it mirrors the gradient table and the
// cell size, predicts every noise value and compares the results in order.
// Depends on gn_pkg and the channel interfaces in gn_ifs.
`timescale 1ns / 1ps

module gn_noise_checker import gn_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    gn_in_if                      sample_in,
    gn_out_if                     noise_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    pending
);

    localparam logic [31:0] HASH_MUL_X = 32'd1836311903;
    localparam logic [31:0] HASH_MUL_Y = 32'd2971215073;
    // 4807526976 reduced modulo 2^32.
    localparam logic [31:0] HASH_ADD   = 32'd512559680;
    localparam longint      ONE_Q16    = 64'sd65536;
    localparam longint      GRAD_LIM   = 64'sd16384;

    longint             tab_gx [TABLE_DEPTH];
    longint             tab_gy [TABLE_DEPTH];
    logic [CELL_W-1:0]  cell_size;
    logic [NOISE_W-1:0] expected_noise [$];

    function automatic longint clamp_grad(logic signed [GRAD_W-1:0] g);
        longint v;
        v = g;
        if (v > GRAD_LIM)
            v = GRAD_LIM;
        if (v < -GRAD_LIM)
            v = -GRAD_LIM;
        return v;
    endfunction

    function automatic longint corner_dot(longint cx, longint cy, longint dx, longint dy);
        logic [31:0]      hx;
        logic [31:0]      hy;
        logic [IDX_W-1:0] idx;
        hx  = 32'(cx) * HASH_MUL_X;
        hy  = 32'(cy) * HASH_MUL_Y + HASH_ADD;
        idx = IDX_W'(hx ^ hy);
        return dx * tab_gx[idx] + dy * tab_gy[idx];
    endfunction

    function automatic longint fade(longint u);
        longint t2;
        longint t3;
        longint inner;
        longint f;
        t2    = (u * u) >>> 16;
        t3    = (t2 * u) >>> 16;
        inner = ((u * (6 * u - 15 * ONE_Q16)) >>> 16) + 10 * ONE_Q16;
        f     = (t3 * inner) >>> 16;
        if (f > ONE_Q16)
            f = ONE_Q16;
        if (f < 0)
            f = 0;
        return f;
    endfunction

    function automatic longint blend(longint a, longint b, longint f);
        return a + (((b - a) * f) >>> 16);
    endfunction

    function automatic logic [NOISE_W-1:0] predict_noise(logic signed [COORD_W-1:0] sx,
                                                         logic signed [COORD_W-1:0] sy);
        longint c, px, py, cx, cy, rx, ry, ux, uy;
        longint d00, d10, d01, d11, fx, fy, upper, lower, n, v;
        c  = (cell_size == 0) ? 1 : longint'(cell_size);
        px = sx;
        py = sy;
        // Floor division, so that the offset always lies in [0,1).
        cx = px / c;
        rx = px % c;
        if (rx < 0)
        begin
            cx = cx - 1;
            rx = rx + c;
        end
        cy = py / c;
        ry = py % c;
        if (ry < 0)
        begin
            cy = cy - 1;
            ry = ry + c;
        end
        ux = (rx << 16) / c;
        uy = (ry << 16) / c;
        d00 = corner_dot(cx,     cy,     ux,           uy);
        d10 = corner_dot(cx + 1, cy,     ux - ONE_Q16, uy);
        d01 = corner_dot(cx,     cy + 1, ux,           uy - ONE_Q16);
        d11 = corner_dot(cx + 1, cy + 1, ux - ONE_Q16, uy - ONE_Q16);
        fx    = fade(ux);
        fy    = fade(uy);
        upper = blend(d00, d10, fx);
        lower = blend(d01, d11, fx);
        n     = blend(upper, lower, fy);
        v     = (n + (64'sd1 <<< 30)) >>> 15;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return NOISE_W'(v);
    endfunction

    assign pending = expected_noise.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size  <= CELL_SIZE_RESET;
            mismatches <= 0;
            expected_noise.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_CELL_SIZE)
                cell_size <= pwdata[CELL_W-1:0];

            if (sample_in.valid && sample_in.ready)
            begin
                if (opcode_t'(sample_in.opcode) == OP_LOAD)
                begin
                    tab_gx[sample_in.entry_index] = clamp_grad(sample_in.grad_x);
                    tab_gy[sample_in.entry_index] = clamp_grad(sample_in.grad_y);
                end
                else
                    expected_noise.insert(expected_noise.size(),
                                          predict_noise(sample_in.sample_x,
                                                        sample_in.sample_y));
            end

            if (noise_out.valid && noise_out.ready)
            begin
                if (expected_noise.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: noise result %0d with none expected", $realtime,
                                 noise_out.noise_value);
                    mismatches <= mismatches + 1;
                end
                else if (noise_out.noise_value !== expected_noise[0])
                begin
                    if (mismatches < 10)
                        $display("%0t: noise_value expected %0d, got %0d", $realtime,
                                 expected_noise[0], noise_out.noise_value);
                    mismatches <= mismatches + 1;
                    void'(expected_noise.pop_front());
                end
                else
                    void'(expected_noise.pop_front());
            end
        end
    end

endmodule

// ===== tb/sv/tb_gradient_noise_2d.sv =====
// Top of the gradient noise testbench: clock, reset, stimulus, register writes and verdict.
// Depends on gn_pkg, gn_ifs, the block gradient_noise_2d and the checker gn_noise_checker.
`timescale 1ns / 1ps

module tb_gradient_noise_2d;
    import gn_pkg::*;

    // The block answers a transfer once it has passed the whole pipeline; leave a margin over that.
    localparam int SETTLE_CYCLES = 70;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 85;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_request;
    bit hold_done;

    gn_in_if  sample_in ();
    gn_out_if noise_out ();

    gradient_noise_2d uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .noise_out (noise_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    gn_noise_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .noise_out  (noise_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The long hold-off of the receiver is counted here, apart from the stimulus.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request && !hold_done)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    // The receiver: random stalls at the rate of the current phase, none during the hold-off.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            noise_out.ready <= 1'b0;
        else
            noise_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one item and returns at the rising edge at which it is transferred. Ready is
    // looked at on the falling edge, where nothing else is changing.
    task automatic offer_item(opcode_t op, logic signed [COORD_W-1:0] sx,
                              logic signed [COORD_W-1:0] sy, logic [IDX_W-1:0] idx,
                              logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_in.valid <= 1'b0;
            @(posedge clk);
        end
        sample_in.valid       <= 1'b1;
        sample_in.opcode      <= op;
        sample_in.sample_x    <= sx;
        sample_in.sample_y    <= sy;
        sample_in.entry_index <= idx;
        sample_in.grad_x      <= gx;
        sample_in.grad_y      <= gy;
        @(negedge clk);
        while (!sample_in.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic load_gradient(logic [IDX_W-1:0] idx);
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        // Mostly in-range components, now and then full-width ones that get saturated.
        if ($urandom_range(9) == 0)
        begin
            gx = GRAD_W'($urandom);
            gy = GRAD_W'($urandom);
        end
        else
        begin
            gx = GRAD_W'($urandom_range(32768) - 16384);
            gy = GRAD_W'($urandom_range(32768) - 16384);
        end
        offer_item(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom), idx, gx, gy);
    endtask

    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(9))
            0:       return {1'b1, {(COORD_W-1){1'b0}}};
            1:       return {1'b0, {(COORD_W-1){1'b1}}};
            2, 3, 4: return COORD_W'($urandom_range(20000) - 10000);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Register write: setup cycle, then access cycle.
    task automatic write_register(reg_idx_t which, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every noise result has come back and the pipeline has drained of loads.
    task automatic drain();
        sample_in.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    logic [CELL_W-1:0] phase_cell [6];

    initial
    begin
        rst_n           = 1'b0;
        cycles          = 0;
        hold_left       = 0;
        hold_request    = 1'b0;
        hold_done       = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        sample_in.valid = 1'b0;
        sample_in.opcode      = OP_LOAD;
        sample_in.sample_x    = '0;
        sample_in.sample_y    = '0;
        sample_in.entry_index = '0;
        sample_in.grad_x      = '0;
        sample_in.grad_y      = '0;
        noise_out.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_register(REG_CELL_SIZE, 32'd70);
        // A write to the unused address must leave the cell size alone.
        write_register(REG_NONE, 32'hFFFF_FFFF);

        // Every table entry is written before the first evaluate, since the corner hash can
        // land anywhere. The extreme components sit in the first few entries.
        offer_item(OP_LOAD, '0, '0, 10'd0, 16'sh7FFF, 16'sh8000);
        offer_item(OP_LOAD, '0, '0, 10'd1, 16'sd16384, -16'sd16384);
        offer_item(OP_LOAD, '0, '0, 10'd2, 16'sd16385, -16'sd16385);
        offer_item(OP_LOAD, '0, '0, 10'd3, 16'sd0, -16'sd1);
        for (int i = 4; i < TABLE_DEPTH; i++)
            load_gradient(IDX_W'(i));

        // Directed evaluates at the corners of the coordinate range and around the cell edges.
        offer_item(OP_EVAL, 24'sd0, 24'sd0, '0, '0, '0);
        offer_item(OP_EVAL, -24'sd1, -24'sd1, '0, '0, '0);
        offer_item(OP_EVAL, 24'sh7FFFFF, 24'sh7FFFFF, '0, '0, '0);
        offer_item(OP_EVAL, 24'sh800000, 24'sh800000, '0, '0, '0);
        offer_item(OP_EVAL, 24'sh800000, 24'sh7FFFFF, '0, '0, '0);
        offer_item(OP_EVAL, 24'sd69, 24'sd69, '0, '0, '0);
        offer_item(OP_EVAL, 24'sd70, -24'sd70, '0, '0, '0);
        offer_item(OP_EVAL, 24'sd35, -24'sd35, '0, '0, '0);
        offer_item(OP_EVAL, -24'sd71, 24'sd139, '0, '0, '0);

        // Settings per phase: the reset value, both extremes, zero (taken as one) and two
        // random sizes.
        phase_cell[0] = 12'd70;
        phase_cell[1] = 12'd1;
        phase_cell[2] = 12'd4095;
        phase_cell[3] = 12'd0;
        phase_cell[4] = CELL_W'($urandom_range(4095, 1));
        phase_cell[5] = CELL_W'($urandom_range(300, 2));

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            // Random upper bits must be ignored by the register.
            write_register(REG_CELL_SIZE, {(APB_DATA_W-CELL_W)'($urandom), phase_cell[ph]});
            if (ph < 2)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 61;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // With nobody idling, the receiver stops for a long stretch so the block fills.
            if (ph == 4)
                hold_request = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(99) < 15)
                    load_gradient(IDX_W'($urandom));
                else
                    offer_item(OP_EVAL, random_coord(), random_coord(), IDX_W'($urandom),
                               GRAD_W'($urandom), GRAD_W'($urandom));
            end
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
